// File: rtl/i2cbe_pkg.sv
package i2cbe_pkg;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_WRITE   = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_ACK     = 3'd5;
  localparam logic [2:0] CMD_NACK    = 3'd6;
  localparam logic [2:0] CMD_WAITACK = 3'd7;

  localparam logic [15:0] QUANTUM_RESET = 16'd100;

  typedef struct packed {
    logic scl;
    logic sda;
  } pins_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       ack;
  } res_t;

  // Number of pin segments that make up each command.
  function automatic logic [4:0] seg_count(input logic [2:0] cmd);
    logic [4:0] n;
    unique case (cmd)
      CMD_START:   n = 5'd2;
      CMD_STOP:    n = 5'd2;
      CMD_WRITE:   n = 5'd17;
      CMD_READ:    n = 5'd16;
      CMD_ACK:     n = 5'd4;
      CMD_NACK:    n = 5'd4;
      CMD_WAITACK: n = 5'd3;
      default:     n = 5'd0;
    endcase
    return n;
  endfunction

  // Pin levels driven while segment s of a command is held.
  function automatic pins_t seg_pins(input logic [2:0] cmd, input logic [4:0] s,
                                     input logic bit_v, input pins_t prev);
    pins_t p;
    p = prev;
    unique case (cmd)
      CMD_START: begin
        p.scl = 1'b1;
        p.sda = (s == 5'd0);
      end
      CMD_STOP: begin
        p.scl = 1'b1;
        p.sda = (s != 5'd0);
      end
      CMD_WRITE: begin
        if (s == 5'd0) begin
          p.scl = 1'b0;
        end else begin
          p.scl = ~s[0];
          p.sda = bit_v;
        end
      end
      CMD_READ: begin
        p.scl = s[0];
        p.sda = 1'b1;
      end
      CMD_ACK: begin
        if (s == 5'd0) begin
          p.scl = 1'b0;
        end else begin
          p.scl = (s == 5'd2);
          p.sda = 1'b0;
        end
      end
      CMD_NACK: begin
        if (s == 5'd0) begin
          p.scl = 1'b0;
        end else begin
          p.scl = (s == 5'd2);
          p.sda = 1'b1;
        end
      end
      CMD_WAITACK: begin
        p.sda = 1'b1;
        if (s != 5'd0) begin
          p.scl = (s == 5'd1);
        end
      end
      default: p = prev;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/i2cbe_seq.sv
module i2cbe_seq
  import i2cbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_en_i,
  input  logic [2:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        sda_in_i,
  input  logic [15:0] quantum_i,
  output res_t        res_o
);

  logic [2:0]  cmd_q, cmd_d;
  logic [4:0]  step_q, step_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  shift_q, shift_d;
  pins_t       pins_q, pins_d;
  logic [7:0]  rdata_q, rdata_d;
  logic        ack_q, ack_d;
  logic        done;

  logic [15:0] quantum;
  logic [15:0] tick_inc;
  logic [4:0]  step_inc;
  logic [7:0]  shift_smp;
  logic        seg_end;

  assign quantum  = (quantum_i == 16'd0) ? 16'd1 : quantum_i;
  assign tick_inc = tick_q + 16'd1;
  assign step_inc = step_q + 5'd1;
  assign seg_end  = (tick_inc >= quantum);

  always_comb begin
    shift_smp = shift_q;
    if (cmd_q == CMD_READ && step_q[0] && tick_inc == 16'd1) begin
      shift_smp = {shift_q[6:0], sda_in_i};
    end
  end

  always_comb begin
    cmd_d   = cmd_q;
    step_d  = step_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    pins_d  = pins_q;
    rdata_d = rdata_q;
    ack_d   = ack_q;
    done    = 1'b0;
    if (cmd_q == CMD_NONE) begin
      if (func_i != CMD_NONE) begin
        cmd_d   = func_i;
        step_d  = 5'd0;
        tick_d  = 16'd0;
        shift_d = (func_i == CMD_WRITE) ? data_byte_i : 8'd0;
        pins_d  = seg_pins(func_i, 5'd0, 1'b0, pins_q);
      end
    end else begin
      tick_d  = tick_inc;
      shift_d = shift_smp;
      if (cmd_q == CMD_WAITACK && step_q == 5'd1 && seg_end) begin
        ack_d = sda_in_i;
      end
      if (seg_end) begin
        tick_d = 16'd0;
        if (cmd_q == CMD_WRITE && step_q != 5'd0 && !step_q[0]) begin
          shift_d = {shift_smp[6:0], 1'b0};
        end
        step_d = step_inc;
        if (step_inc >= seg_count(cmd_q)) begin
          done   = 1'b1;
          cmd_d  = CMD_NONE;
          step_d = 5'd0;
          unique case (cmd_q)
            CMD_START: pins_d = '{scl: 1'b1, sda: 1'b0};
            CMD_STOP:  pins_d = '{scl: 1'b1, sda: 1'b1};
            CMD_WRITE: pins_d = '{scl: 1'b0, sda: pins_q.sda};
            CMD_READ: begin
              rdata_d = shift_smp;
              pins_d  = '{scl: 1'b1, sda: 1'b1};
            end
            default:   pins_d = '{scl: 1'b0, sda: 1'b1};
          endcase
        end else begin
          pins_d = seg_pins(cmd_q, step_inc, shift_d[7], pins_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CMD_NONE;
      step_q  <= 5'd0;
      tick_q  <= 16'd0;
      shift_q <= 8'd0;
      pins_q  <= '{scl: 1'b1, sda: 1'b1};
      rdata_q <= 8'd0;
      ack_q   <= 1'b1;
    end else if (step_en_i) begin
      cmd_q   <= cmd_d;
      step_q  <= step_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      pins_q  <= pins_d;
      rdata_q <= rdata_d;
      ack_q   <= ack_d;
    end
  end

  assign res_o = '{scl: pins_d.scl, sda: pins_d.sda, busy: (cmd_d != CMD_NONE),
                   done: done, rdata: rdata_d, ack: ack_d};

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == CMD_NONE |-> step_q == 5'd0 && tick_q == 16'd0)
    else $error("idle sequencer holds a stale step or tick count");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q != CMD_NONE |-> step_q < seg_count(cmd_q))
    else $error("step index beyond the command's last segment");

  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q != CMD_NONE |-> tick_q < quantum)
    else $error("tick count reached the quantum without advancing");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && done |=> cmd_q == CMD_NONE)
    else $error("sequencer still busy after finishing a command");

endmodule

// File: rtl/i2c_master_bit_engine.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  func_i, data_byte_i, sda_in_i
// out      output     out_valid_o / out_stall_i scl_out_o, sda_out_o, busy_res_o,
//                                               done_res_o, read_data_o, ack_bit_o
// cfg      input      cfg_we_i                 cfg_wdata_i (quantum_ticks)
//
// Every input transaction is one tick and yields exactly one output transaction.
// The sequencer state and the output register both update at the accepting edge, so
// the result shows next cycle; one tick is taken per cycle unless the input stalls.
// Reset returns the sequencer to idle with both pins released and quantum_ticks at 100.
// While the output register is full and stalled, the input is stalled too.
module i2c_master_bit_engine
  import i2cbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_data_o,
  output logic        ack_bit_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] quantum_q;
  logic        out_valid_q, out_valid_d;
  res_t        res_q;
  res_t        res_next;
  logic        accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  i2cbe_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (accept),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .sda_in_i    (sda_in_i),
    .quantum_i   (quantum_q),
    .res_o       (res_next)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q   <= QUANTUM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = res_q.scl;
  assign sda_out_o   = res_q.sda;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign read_data_o = res_q.rdata;
  assign ack_bit_o   = res_q.ack;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted transaction left no result");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done |-> !res_q.busy)
    else $error("result reports done while still busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !accept)
    else $error("input accepted over a stalled result");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import i2cbe_pkg::*;

  typedef struct packed {
    logic        is_cfg;
    logic [15:0] qval;
    logic [2:0]  func;
    logic [7:0]  data;
    logic        sda;
    logic [7:0]  reps;
    logic        typed;
    res_t        want;
  } plan_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [2:0]  func_i      = CMD_NONE;
  logic [7:0]  data_byte_i = 8'h00;
  logic        sda_in_i    = 1'b1;
  logic        out_stall_i = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = 16'h0000;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  read_data_o;
  logic        ack_bit_o;

  // Bus engine mirror.
  logic [15:0] quantum_q = QUANTUM_RESET;
  logic [2:0]  cur_cmd = CMD_NONE;
  logic [4:0]  seg_idx = 5'd0;
  logic [15:0] hold_cnt = 16'd0;
  logic [7:0]  bit_shift = 8'h00;
  logic        scl_drv = 1'b1;
  logic        sda_drv = 1'b1;
  logic [7:0]  last_rd_byte = 8'h00;
  logic        last_ack = 1'b1;

  res_t        bus_result_q[$];
  plan_row_t   dir_plan[$];
  int          fault_count = 0;
  int          rx_count = 0;
  bit          gapless = 1'b0;

  i2c_master_bit_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .read_data_o (read_data_o),
    .ack_bit_o   (ack_bit_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [4:0] segments_of(input logic [2:0] cmd);
    case (cmd)
      CMD_START, CMD_STOP: return 5'd2;
      CMD_WRITE:           return 5'd17;
      CMD_READ:            return 5'd16;
      CMD_ACK, CMD_NACK:   return 5'd4;
      CMD_WAITACK:         return 5'd3;
      default:             return 5'd0;
    endcase
  endfunction

  function automatic void apply_segment_pins();
    case (cur_cmd)
      CMD_START: begin
        scl_drv = 1'b1;
        sda_drv = (seg_idx == 5'd0);
      end
      CMD_STOP: begin
        scl_drv = 1'b1;
        sda_drv = (seg_idx != 5'd0);
      end
      CMD_WRITE: begin
        if (seg_idx == 5'd0) begin
          scl_drv = 1'b0;
        end else begin
          scl_drv = ~seg_idx[0];
          sda_drv = bit_shift[7];
        end
      end
      CMD_READ: begin
        scl_drv = seg_idx[0];
        sda_drv = 1'b1;
      end
      CMD_ACK, CMD_NACK: begin
        if (seg_idx == 5'd0) begin
          scl_drv = 1'b0;
        end else begin
          scl_drv = (seg_idx == 5'd2);
          sda_drv = (cur_cmd == CMD_NACK);
        end
      end
      CMD_WAITACK: begin
        sda_drv = 1'b1;
        if (seg_idx != 5'd0) begin
          scl_drv = (seg_idx == 5'd1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void close_command();
    case (cur_cmd)
      CMD_START: begin
        scl_drv = 1'b1;
        sda_drv = 1'b0;
      end
      CMD_STOP: begin
        scl_drv = 1'b1;
        sda_drv = 1'b1;
      end
      CMD_WRITE: begin
        scl_drv = 1'b0;
      end
      CMD_READ: begin
        last_rd_byte = bit_shift;
        scl_drv = 1'b1;
        sda_drv = 1'b1;
      end
      default: begin
        scl_drv = 1'b0;
        sda_drv = 1'b1;
      end
    endcase
    cur_cmd = CMD_NONE;
    seg_idx = 5'd0;
    hold_cnt = 16'd0;
  endfunction

  function automatic res_t advance_bus_tick(input logic [2:0] f, input logic [7:0] d,
                                            input logic s_in);
    res_t        r;
    logic [15:0] q;
    logic [4:0]  s;
    logic        fin;
    q = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
    fin = 1'b0;
    if (cur_cmd == CMD_NONE) begin
      if (f != CMD_NONE) begin
        cur_cmd = f;
        seg_idx = 5'd0;
        hold_cnt = 16'd0;
        bit_shift = (f == CMD_WRITE) ? d : 8'h00;
        apply_segment_pins();
      end
    end else begin
      s = seg_idx;
      hold_cnt = hold_cnt + 16'd1;
      if (cur_cmd == CMD_READ && s[0] && hold_cnt == 16'd1) begin
        bit_shift = {bit_shift[6:0], s_in};
      end
      if (cur_cmd == CMD_WAITACK && s == 5'd1 && hold_cnt >= q) begin
        last_ack = s_in;
      end
      if (hold_cnt >= q) begin
        hold_cnt = 16'd0;
        if (cur_cmd == CMD_WRITE && s != 5'd0 && !s[0]) begin
          bit_shift = {bit_shift[6:0], 1'b0};
        end
        seg_idx = s + 5'd1;
        if (seg_idx >= segments_of(cur_cmd)) begin
          close_command();
          fin = 1'b1;
        end else begin
          apply_segment_pins();
        end
      end
    end
    r.scl   = scl_drv;
    r.sda   = sda_drv;
    r.busy  = (cur_cmd != CMD_NONE);
    r.done  = fin;
    r.rdata = last_rd_byte;
    r.ack   = last_ack;
    return r;
  endfunction

  function automatic plan_row_t tick_row(input logic [2:0] f, input logic [7:0] d,
                                         input logic s, input logic [7:0] n,
                                         input logic typed, input res_t want);
    plan_row_t row;
    row = '0;
    row.func = f;
    row.data = d;
    row.sda = s;
    row.reps = n;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [15:0] v);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.qval = v;
    return row;
  endfunction

  task automatic send_tick(input logic [2:0] f, input logic [7:0] d, input logic s,
                           input logic typed, input res_t want);
    int   gap;
    res_t nxt;
    gap = gapless ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    data_byte_i <= d;
    sda_in_i    <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    nxt = advance_bus_tick(f, d, s);
    bus_result_q.push_back(typed ? want : nxt);
  endtask

  task automatic drain_to_idle();
    while (cur_cmd != CMD_NONE) begin
      send_tick(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  task automatic set_quantum(input logic [15:0] v);
    drain_to_idle();
    in_valid_i <= 1'b0;
    while (bus_result_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    quantum_q = v;
  endtask

  task automatic run_bus_traffic(input int n);
    logic [2:0] f;
    for (int i = 0; i < n; i++) begin
      if (cur_cmd == CMD_NONE && $urandom_range(0, 3) != 0) begin
        f = 3'($urandom_range(1, 7));
      end else if ($urandom_range(0, 15) == 0) begin
        f = 3'($urandom_range(0, 7));
      end else begin
        f = CMD_NONE;
      end
      send_tick(f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (bus_result_q.size() == 0) begin
      $error("result transaction with nothing expected");
      fault_count++;
      return;
    end
    want = bus_result_q.pop_front();
    if (got.scl !== want.scl) begin
      $error("scl_out: expected %0d, got %0d", want.scl, got.scl);
      fault_count++;
    end
    if (got.sda !== want.sda) begin
      $error("sda_out: expected %0d, got %0d", want.sda, got.sda);
      fault_count++;
    end
    if (got.busy !== want.busy) begin
      $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
      fault_count++;
    end
    if (got.done !== want.done) begin
      $error("done_res: expected %0d, got %0d", want.done, got.done);
      fault_count++;
    end
    if (got.rdata !== want.rdata) begin
      $error("read_data: expected %02h, got %02h", want.rdata, got.rdata);
      fault_count++;
    end
    if (got.ack !== want.ack) begin
      $error("ack_bit: expected %0d, got %0d", want.ack, got.ack);
      fault_count++;
    end
  endtask

  initial begin
    int hold;
    wait (rst_ni === 1'b1);
    forever begin
      // One long hold-off lets the block fill up and stall its input.
      hold = (rx_count == 700) ? 300 : (gapless ? 0 : $urandom_range(0, 19));
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      check_result({scl_out_o, sda_out_o, busy_res_o, done_res_o, read_data_o, ack_bit_o});
      rx_count++;
    end
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    dir_plan.push_back(tick_row(CMD_NONE, 8'h00, 1'b0, 8'd1, 1'b1,
                                {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}));
    dir_plan.push_back(tick_row(CMD_NONE, 8'hFF, 1'b1, 8'd1, 1'b1,
                                {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}));
    dir_plan.push_back(tick_row(CMD_START, 8'hFF, 1'b1, 8'd1, 1'b1,
                                {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1}));
    dir_plan.push_back(tick_row(CMD_STOP, 8'h00, 1'b0, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'h00, 1'b1, 8'd4, 1'b0, '0));
    dir_plan.push_back(cfg_row(16'd1));
    dir_plan.push_back(tick_row(CMD_WRITE, 8'hFF, 1'b0, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'h00, 1'b0, 8'd18, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_WRITE, 8'h00, 1'b1, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'h00, 1'b1, 8'd18, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_WRITE, 8'hA5, 1'b0, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'h5A, 1'b0, 8'd18, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_READ, 8'h00, 1'b1, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'h00, 1'b1, 8'd18, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_READ, 8'hFF, 1'b0, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'hFF, 1'b0, 8'd18, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_ACK, 8'h00, 1'b1, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'h00, 1'b1, 8'd5, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NACK, 8'h00, 1'b0, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'h00, 1'b0, 8'd5, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_WAITACK, 8'h00, 1'b0, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'h00, 1'b0, 8'd4, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_WAITACK, 8'h00, 1'b1, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'h00, 1'b1, 8'd4, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_STOP, 8'h00, 1'b0, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'h00, 1'b0, 8'd3, 1'b0, '0));
    dir_plan.push_back(cfg_row(16'd0));
    dir_plan.push_back(tick_row(CMD_START, 8'h00, 1'b0, 8'd1, 1'b0, '0));
    dir_plan.push_back(tick_row(CMD_NONE, 8'h00, 1'b0, 8'd3, 1'b0, '0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_plan[i]) begin
      if (dir_plan[i].is_cfg) begin
        set_quantum(dir_plan[i].qval);
      end else begin
        repeat (dir_plan[i].reps) begin
          send_tick(dir_plan[i].func, dir_plan[i].data, dir_plan[i].sda,
                    dir_plan[i].typed, dir_plan[i].want);
        end
      end
    end

    set_quantum(16'd1);
    run_bus_traffic(160);
    set_quantum(16'd2);
    gapless = 1'b1;
    run_bus_traffic(140);
    set_quantum(16'd0);
    gapless = 1'b0;
    run_bus_traffic(160);
    set_quantum(16'd3);
    run_bus_traffic(160);
    set_quantum(16'($urandom_range(4, 9)));
    run_bus_traffic(160);
    set_quantum(16'd1);
    run_bus_traffic(110);
    // The widest quantum goes last since a single command never finishes within the run.
    set_quantum(16'hFFFF);
    gapless = 1'b1;
    run_bus_traffic(90);

    in_valid_i <= 1'b0;
    while (bus_result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fault_count == 0 && bus_result_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/i2cbe_pkg.sv
rtl/i2cbe_seq.sv
rtl/i2c_master_bit_engine.sv
sim/tb.sv
